// ===== rtl/tts_pkg.sv =====
// shared types and constants for the tridiagonal solver
package tts_pkg;

  localparam int unsigned QW = 32;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SINGULAR = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [31:0] sub_diag;
    logic signed [31:0] main_diag;
    logic signed [31:0] super_diag;
    logic signed [31:0] rhs_value;
    logic               last_row;
  } row_t;

  typedef struct packed {
    logic signed [31:0] x_value;
    logic [5:0]         x_index;
    logic               last_result;
    logic [1:0]         status;
  } sol_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_MUL1W,
    S_SUB,
    S_DIV1,
    S_DIV1W,
    S_DIV2,
    S_DIV2W,
    S_WRITE,
    S_ERR,
    S_BRD,
    S_BMUL,
    S_BMULW,
    S_BOUT
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load_row;
    logic mul_a_c;
    logic mul_a_d;
    logic form_pivot;
    logic div_c;
    logic div_d;
    logic div_start;
    logic write_row;
    logic rd_back;
    logic mul_back;
    logic form_x;
    logic out_load;
    logic out_err;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic div_busy;
    logic singular;
  } dstat_t;

  // saturate a 64 bit value to 32 bit signed
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_0000_7FFF_FFFF;
    lo = -64'sh0000_0000_8000_0000;
    if (v > hi) sat32 = 32'sh7FFF_FFFF;
    else if (v < lo) sat32 = 32'sh8000_0000;
    else sat32 = v[31:0];
  endfunction

endpackage

// ===== rtl/tts_div.sv =====
// iterative signed divider: (num << 16) / den, truncating, saturating
module tts_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] num_i,
  input  logic signed [31:0] den_i,
  output logic               busy_o,
  output logic signed [31:0] quo_o
);
  import tts_pkg::*;

  logic [47:0] rem_q, rem_d;
  logic [47:0] quo_q, quo_d;
  logic [31:0] den_q, den_d;
  logic        neg_q, neg_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [48:0] trial;
  logic [47:0] shifted;
  logic signed [63:0] res;

  // one quotient bit per cycle, restoring form
  always_comb begin
    rem_d   = rem_q;
    quo_d   = quo_q;
    den_d   = den_q;
    neg_d   = neg_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    shifted = {rem_q[46:0], quo_q[47]};
    trial   = {1'b0, shifted} - {17'd0, den_q};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = {(num_i[31] ? 32'(-num_i) : 32'(num_i)), 16'd0};
      den_d  = den_i[31] ? 32'(-den_i) : 32'(den_i);
      neg_d  = num_i[31] ^ den_i[31];
      cnt_d  = 6'd48;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[48]) begin
        rem_d = trial[47:0];
        quo_d = {quo_q[46:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[46:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  // sign and saturate the magnitude
  always_comb begin
    res   = neg_q ? -$signed({16'd0, quo_q}) : $signed({16'd0, quo_q});
    quo_o = sat32(res);
  end

  assign busy_o = busy_q;
endmodule

// ===== rtl/tts_datapath.sv =====
// forward elimination and back substitution datapath with coefficient stores
module tts_datapath #(
  parameter int unsigned MAX_ROWS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tts_pkg::row_t       row_i,
  input  logic [16:0]         thr_i,
  input  logic [6:0]          row_idx_i,
  input  logic [6:0]          back_idx_i,
  input  logic                back_last_i,
  input  tts_pkg::status_e    err_i,
  input  tts_pkg::cmd_t       cmd_i,
  output tts_pkg::dstat_t     stat_o,
  output tts_pkg::sol_t       sol_o
);
  import tts_pkg::*;

  localparam int unsigned AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic signed [31:0] upper_mem [MAX_ROWS];
  logic signed [31:0] rhs_mem   [MAX_ROWS];
  logic signed [31:0] rd_u_q, rd_r_q;
  row_t               row_q;
  logic signed [31:0] prod_q, piv_q, num_q, cq_q, x_q;
  logic signed [63:0] mul_full;
  logic signed [31:0] mul_a, mul_b, prod_sat;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic               div_busy;
  logic signed [31:0] div_num, quo;
  logic signed [32:0] piv_mag;
  sol_t               sol_q;

  assign wr_addr = row_idx_i[AW-1:0];
  assign rd_addr = cmd_i.rd_back ? back_idx_i[AW-1:0] : AW'(row_idx_i - 7'd1);

  // coefficient stores
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_row) begin
      upper_mem[wr_addr] <= row_q.last_row ? 32'sd0 : cq_q;
      rhs_mem[wr_addr]   <= quo;
    end
    rd_u_q <= upper_mem[rd_addr];
    rd_r_q <= rhs_mem[rd_addr];
  end

  // shared multiplier, result registered
  always_comb begin
    mul_a = cmd_i.mul_back ? rd_u_q : row_q.sub_diag;
    mul_b = cmd_i.mul_back ? x_q : (cmd_i.mul_a_c ? rd_u_q : rd_r_q);
    mul_full = 64'(mul_a) * 64'(mul_b);
    prod_sat = sat32(mul_full / 64'sd65536);
  end

  tts_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (div_num),
    .den_i  (piv_q),
    .busy_o (div_busy),
    .quo_o  (quo)
  );
  assign div_num = cmd_i.div_d ? num_q : row_q.super_diag;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_row) row_q <= row_i;
    if (cmd_i.mul_a_c || cmd_i.mul_a_d || cmd_i.mul_back) prod_q <= prod_sat;
    // pivot and numerator; first row bypasses the update
    if (cmd_i.load_row) begin
      piv_q <= row_i.main_diag;
      num_q <= row_i.rhs_value;
    end
    if (cmd_i.form_pivot && row_idx_i != 7'd0) begin
      if (cmd_i.mul_a_c)
        piv_q <= sat32(64'(row_q.main_diag) - 64'(prod_q));
      else
        num_q <= sat32(64'(row_q.rhs_value) - 64'(prod_q));
    end
    if (cmd_i.div_c) cq_q <= quo;
    if (cmd_i.form_x)
      x_q <= (back_last_i) ? rd_r_q : sat32(64'(rd_r_q) - 64'(prod_q));
    if (cmd_i.out_load) begin
      sol_q.x_value     <= (back_last_i) ? rd_r_q : sat32(64'(rd_r_q) - 64'(prod_q));
      sol_q.x_index     <= back_idx_i[5:0];
      sol_q.last_result <= (back_idx_i == 7'd0);
      sol_q.status      <= ST_OK;
    end
    if (cmd_i.out_err) begin
      sol_q.x_value     <= '0;
      sol_q.x_index     <= '0;
      sol_q.last_result <= 1'b1;
      sol_q.status      <= err_i;
    end
  end

  assign piv_mag = piv_q[31] ? -33'(piv_q) : 33'(piv_q);
  assign stat_o.singular = (piv_mag <= $signed({16'd0, thr_i})) || (piv_q == 32'sd0);
  assign stat_o.div_busy = div_busy;
  assign sol_o = sol_q;
endmodule

// ===== rtl/tts_ctrl.sv =====
// sequencer for row elimination, back substitution and result handoff
module tts_ctrl #(
  parameter int unsigned MAX_ROWS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [6:0]        row_idx_o,
  output logic [6:0]        back_idx_o,
  output logic              back_last_o,
  output tts_pkg::status_e  err_o,
  output tts_pkg::cmd_t     cmd_o,
  input  tts_pkg::dstat_t   stat_i
);
  import tts_pkg::*;

  state_e     state_q, state_d;
  logic [6:0] cnt_q, cnt_d;
  logic       sing_q, sing_d, ovf_q, ovf_d, last_q, last_d;
  logic [6:0] bidx_q, bidx_d;
  logic       first_q, first_d;
  logic       ov_q, ov_d;
  logic       accept, out_free;

  assign out_free = !ov_q || !out_stall_i;
  assign accept   = (state_q == S_IDLE) && in_valid_i;

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q; sing_d = sing_q; ovf_d = ovf_q; last_d = last_q;
    bidx_d = bidx_q; first_d = first_q;
    ov_d = ov_q && out_stall_i;
    case (state_q)
      S_IDLE: if (in_valid_i) begin
        last_d = in_last_i;
        if (cnt_q >= 7'(MAX_ROWS)) begin
          ovf_d = 1'b1;
          state_d = in_last_i ? S_ERR : S_IDLE;
        end else if (sing_q) begin
          cnt_d = cnt_q + 7'd1;
          state_d = in_last_i ? S_ERR : S_IDLE;
        end else state_d = S_MUL1;
      end
      S_MUL1:  state_d = S_MUL1W;
      S_MUL1W: state_d = S_SUB;
      S_SUB:   state_d = S_DIV1;
      S_DIV1:  if (stat_i.singular) begin
        sing_d = 1'b1; cnt_d = cnt_q + 7'd1;
        state_d = last_q ? S_ERR : S_IDLE;
      end else state_d = S_DIV1W;
      S_DIV1W: if (!stat_i.div_busy) state_d = S_DIV2;
      S_DIV2:  state_d = S_DIV2W;
      S_DIV2W: if (!stat_i.div_busy) state_d = S_WRITE;
      S_WRITE: begin
        cnt_d = cnt_q + 7'd1;
        if (last_q) begin
          bidx_d = cnt_q; first_d = 1'b1;
          state_d = ovf_q ? S_ERR : S_BRD;
        end else state_d = S_IDLE;
      end
      S_ERR: if (out_free) begin
        ov_d = 1'b1; cnt_d = '0; sing_d = 1'b0; ovf_d = 1'b0;
        state_d = S_IDLE;
      end
      S_BRD:   state_d = first_q ? S_BOUT : S_BMUL;
      S_BMUL:  state_d = S_BMULW;
      S_BMULW: state_d = S_BOUT;
      S_BOUT:  if (out_free) begin
        ov_d = 1'b1; first_d = 1'b0;
        if (bidx_q == 7'd0) begin
          cnt_d = '0; sing_d = 1'b0; ovf_d = 1'b0;
          state_d = S_IDLE;
        end else begin
          bidx_d = bidx_q - 7'd1;
          state_d = S_BRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE:  cmd_o.load_row = accept;
      S_MUL1:  begin cmd_o.mul_a_c = 1'b1; end
      S_MUL1W: begin cmd_o.mul_a_c = 1'b1; cmd_o.form_pivot = 1'b1; end
      S_SUB:   begin cmd_o.mul_a_d = 1'b1; end
      S_DIV1:  begin
        cmd_o.form_pivot = 1'b1;
        cmd_o.div_start = !stat_i.singular;
      end
      S_DIV2:  begin cmd_o.div_c = 1'b1; cmd_o.div_d = 1'b1; cmd_o.div_start = 1'b1; end
      S_WRITE: cmd_o.write_row = 1'b1;
      S_ERR:   cmd_o.out_err = out_free;
      S_BRD:   cmd_o.rd_back = 1'b1;
      S_BMUL:  begin cmd_o.rd_back = 1'b1; cmd_o.mul_back = 1'b1; end
      S_BMULW: cmd_o.rd_back = 1'b1;
      S_BOUT:  begin
        cmd_o.rd_back = 1'b1;
        cmd_o.form_x = out_free;
        cmd_o.out_load = out_free;
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0; sing_q <= 1'b0; ovf_q <= 1'b0; last_q <= 1'b0;
      bidx_q <= '0; first_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d; sing_q <= sing_d; ovf_q <= ovf_d; last_q <= last_d;
      bidx_q <= bidx_d; first_q <= first_d; ov_q <= ov_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = ov_q;
  assign row_idx_o   = cnt_q;
  assign back_idx_o  = bidx_q;
  assign back_last_o = first_q;
  assign err_o       = sing_q ? ST_SINGULAR : ST_OVERFLOW;

  // row count never passes the store depth
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 7'(MAX_ROWS)) else $error("row count out of range");
  // a waiting result holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && out_stall_i |=> ov_q) else $error("result dropped");
  // divider is idle whenever a row may be taken
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !stat_i.div_busy) else $error("divider busy in idle");
endmodule

// ===== rtl/tridiagonal_thomas_solver.sv =====
// top level of the tridiagonal (Thomas) solver
// Usage: one matrix row is taken per input item on in_valid/in_stall; the
// row with last_row set ends the system. Rows are eliminated as they come
// and their modified coefficients held in on-chip stores. After the last
// row the solution leaves on out_valid/out_stall from index n-1 down to 0,
// one item per component, last_result set on index 0. A singular pivot or
// too many rows gives a single status item instead.
// Each row is eliminated in full before the next row is accepted, the time
// set by two 48-step restoring divisions on the shared divider; a row after
// a singular pivot or beyond the store depth is taken without elimination.
// Back substitution reads, multiplies and outputs one component at a time.
// Reset clears the row count and error flags; pivot_threshold resets to 0
// and must be written by the user on cfg_valid/cfg_ready only while idle;
// the block does not enforce this. While the receiver stalls the result
// item holds and the sequencer waits.
module tridiagonal_thomas_solver #(
  parameter int unsigned MAX_ROWS = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid,
  output logic           in_stall,
  input  tts_pkg::row_t  in_data_i,
  output logic           out_valid,
  input  logic           out_stall,
  output tts_pkg::sol_t  out_data_o,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [16:0]    cfg_data_i
);
  import tts_pkg::*;

  logic [16:0] thr_q;
  cmd_t        cmd;
  dstat_t      dstat;
  logic [6:0]  row_idx, back_idx;
  logic        back_last;
  status_e     err;

  // threshold register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) thr_q <= '0;
    else if (cfg_valid) thr_q <= cfg_data_i;
  end

  tts_ctrl #(.MAX_ROWS(MAX_ROWS)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_valid),
    .in_last_i  (in_data_i.last_row),
    .in_stall_o (in_stall),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .row_idx_o  (row_idx),
    .back_idx_o (back_idx),
    .back_last_o(back_last),
    .err_o      (err),
    .cmd_o      (cmd),
    .stat_i     (dstat)
  );

  tts_datapath #(.MAX_ROWS(MAX_ROWS)) u_dp (
    .clk_i, .rst_ni,
    .row_i      (in_data_i),
    .thr_i      (thr_q),
    .row_idx_i  (row_idx),
    .back_idx_i (back_idx),
    .back_last_i(back_last),
    .err_i      (err),
    .cmd_i      (cmd),
    .stat_o     (dstat),
    .sol_o      (out_data_o)
  );
endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench for the tridiagonal solver: directed and random systems against a q16.16 predictor
module tb_top;
  import tts_pkg::*;

  localparam int MAX_ROWS = 64;
  localparam int IDLE_LIMIT = 20000;

  // expected-solution store and checker
  class solution_board;
    sol_t pending[$];
    int unsigned errors;
    logic signed [31:0] c_mod[MAX_ROWS];
    logic signed [31:0] d_mod[MAX_ROWS];
    int unsigned rows;
    bit sing;
    bit ovf;
    logic [16:0] thresh;

    function logic signed [31:0] sat(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
    endfunction

    function logic signed [31:0] qmul(input logic signed [31:0] p, input logic signed [31:0] q);
      logic signed [63:0] prod;
      prod = 64'(p) * 64'(q);
      return sat(prod / 64'sd65536);
    endfunction

    function logic signed [31:0] qdiv(input logic signed [31:0] n, input logic signed [31:0] p);
      logic signed [63:0] num;
      num = 64'(n) * 64'sd65536;
      return sat(num / 64'(p));
    endfunction

    function logic signed [31:0] qsub(input logic signed [31:0] p, input logic signed [31:0] q);
      return sat(64'(p) - 64'(q));
    endfunction

    // forward elimination on one accepted row, back substitution on the last
    function void note_row(input row_t r);
      logic signed [31:0] piv, num, x;
      logic signed [63:0] mag;
      sol_t s;
      int n;
      if (rows >= MAX_ROWS) ovf = 1;
      else begin
        if (!sing) begin
          if (rows == 0) begin
            piv = r.main_diag;
            num = r.rhs_value;
          end else begin
            piv = qsub(r.main_diag, qmul(r.sub_diag, c_mod[rows-1]));
            num = qsub(r.rhs_value, qmul(r.sub_diag, d_mod[rows-1]));
          end
          mag = piv < 0 ? -64'(piv) : 64'(piv);
          if (mag <= 64'(thresh) || piv == 0) sing = 1;
          else begin
            c_mod[rows] = r.last_row ? 32'sd0 : qdiv(r.super_diag, piv);
            d_mod[rows] = qdiv(num, piv);
          end
        end
        rows++;
      end
      if (!r.last_row) return;
      if (sing || ovf) begin
        s = '0;
        s.last_result = 1;
        s.status = sing ? ST_SINGULAR : ST_OVERFLOW;
        pending.push_back(s);
      end else begin
        n = rows;
        x = 0;
        for (int k = 0; k < n; k++) begin
          if (k == 0) x = d_mod[n-1];
          else x = qsub(d_mod[n-1-k], qmul(c_mod[n-1-k], x));
          s.x_value = x;
          s.x_index = 6'(n - 1 - k);
          s.last_result = (k + 1 == n);
          s.status = ST_OK;
          pending.push_back(s);
        end
      end
      rows = 0;
      sing = 0;
      ovf = 0;
    endfunction

    function void check_solution(input sol_t got);
      sol_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected item: %p", got);
        return;
      end
      want = pending.pop_front();
      if (got.x_value !== want.x_value || got.x_index !== want.x_index ||
          got.last_result !== want.last_result || got.status !== want.status) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  row_t in_data_i;
  sol_t out_data_o;
  logic [16:0] cfg_data_i;
  solution_board board;
  int idle_cycles;
  int rows_sent;

  tridiagonal_thomas_solver u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid(in_valid), .in_stall(in_stall), .in_data_i(in_data_i),
    .out_valid(out_valid), .out_stall(out_stall), .out_data_o(out_data_o),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data_i(cfg_data_i)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // short gaps mostly, occasionally long
  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 150);
  endfunction

  // receiver stall pattern and result checking
  initial begin
    int hold;
    out_stall = 1'b0;
    hold = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid && !out_stall) board.check_solution(out_data_o);
      if (hold > 0) hold--;
      else if (out_stall) out_stall <= 1'b0;
      else if ($urandom_range(0, 3) == 0) begin
        hold = gap_len();
        if (hold > 0) out_stall <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // valid stays high across rows sent with no gap
  task automatic send_row(input row_t r);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data_i <= r;
    do @(posedge clk_i); while (in_stall);
    board.note_row(r);
    rows_sent++;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [16:0] v);
    cfg_valid <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready);
    board.thresh = v;
    cfg_valid <= 1'b0;
  endtask

  function logic signed [31:0] rand_q(input int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(0, 262143)) - 131072;
      default: return ($urandom_range(0, 1) ? 1 : -1) * $signed($urandom_range(196608, 655360));
    endcase
  endfunction

  // random system of n rows; unless wild, the main diagonal outweighs each off-diagonal
  task automatic send_system(input int n, input bit wild);
    row_t r;
    for (int i = 0; i < n; i++) begin
      r.sub_diag = rand_q(wild ? 0 : 1);
      r.super_diag = rand_q(wild ? 0 : 1);
      r.main_diag = wild ? rand_q(0) : rand_q(2);
      r.rhs_value = wild ? rand_q(0) : rand_q($urandom_range(0, 1));
      r.last_row = (i == n - 1);
      send_row(r);
    end
  endtask

  initial begin
    row_t r;
    board = new();
    board.thresh = 0;
    board.rows = 0;
    board.sing = 0;
    board.ovf = 0;
    board.errors = 0;
    idle_cycles = 0;
    rows_sent = 0;
    in_valid = 0;
    in_data_i = '0;
    cfg_valid = 0;
    cfg_data_i = '0;
    rst_ni = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: single-row extremes with threshold zero
    r = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 1'b1};
    send_row(r);
    r = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1};
    send_row(r);
    // zero pivot, then rows after it only counted
    r = '{32'sd0, 32'sd0, 32'sd65536, 32'sd65536, 1'b0};
    send_row(r);
    r = '{32'sd1, 32'sd65536, 32'sd0, 32'sd5, 1'b1};
    send_row(r);
    // tiny pivot and saturating quotient
    r = '{32'sd0, 32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0};
    send_row(r);
    r = '{32'sd0, 32'sd65536, 32'sd0, 32'sd65536, 1'b1};
    send_row(r);
    // small ordinary system, then threshold edge rows, full-depth and overflow
    send_system(3, 0);
    wait_drain();
    write_threshold(17'd65536);
    r = '{32'sd0, -32'sd65536, 32'sd0, 32'sd65536, 1'b1};
    send_row(r);
    r = '{32'sd0, 32'sd65537, 32'sd0, -32'sd65536, 1'b1};
    send_row(r);
    send_system(MAX_ROWS, 0);
    send_system(MAX_ROWS + 2, 0);
    wait_drain();
    write_threshold(17'd0);

    // random systems across threshold settings
    while (rows_sent < 450) begin
      if ($urandom_range(0, 9) == 0) begin
        wait_drain();
        case ($urandom_range(0, 3))
          0: write_threshold(17'd0);
          1: write_threshold(17'd65536);
          2: write_threshold(17'($urandom_range(0, 65536)));
          default: write_threshold(17'($urandom_range(1, 16)));
        endcase
      end
      case ($urandom_range(0, 19))
        0: send_system($urandom_range(1, 8), 1);
        1: send_system($urandom_range(40, 66), 0);
        default: send_system($urandom_range(1, 8), 0);
      endcase
    end

    wait_drain();
    if (board.errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule

// ===== tridiagonal_thomas_solver.f =====
rtl/tts_pkg.sv
rtl/tts_div.sv
rtl/tts_datapath.sv
rtl/tts_ctrl.sv
rtl/tridiagonal_thomas_solver.sv
verif/tb_top.sv
